// ===== design/datagram_frame_checker_macros.svh =====
// Assertion macros shared by the datagram frame checker RTL
`ifndef DATAGRAM_FRAME_CHECKER_MACROS_SVH
`define DATAGRAM_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define DFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define DFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dfc_pkg.sv =====
// Types and constants of the datagram frame checker
package dfc_pkg;

  localparam int HEADER_BYTES = 18;
  localparam int CRC_SPAN     = 16;
  localparam int COUNT_W      = 17;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [15:0]        CRC_POLY  = 16'h1021;
  localparam logic [15:0]        CRC_INIT  = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY = 2'd2;

  localparam logic [15:0] MAGIC_RST   = 16'h0000;
  localparam logic [7:0]  VERSION_RST = 8'h01;
  localparam logic [15:0] MAX_PAY_RST = 16'd1024;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_FIELD   = 3'd4,
    ST_CRC     = 3'd5
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] magic;
    logic [7:0]  version;
    logic [7:0]  message_type;
    logic [7:0]  flag_bits;
    logic [7:0]  reserved_byte;
    logic [31:0] sequence_res;
    logic [31:0] timestamp;
    logic [15:0] payload_length;
    logic [15:0] frame_checksum;
  } result_t;

endpackage

// ===== design/dfc_in_if.sv =====
// Byte stream channel into the datagram frame checker
interface dfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

// ===== design/dfc_out_if.sv =====
// Verdict channel out of the datagram frame checker
interface dfc_out_if import dfc_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [15:0] magic;
  logic [7:0]  version;
  logic [7:0]  message_type;
  logic [7:0]  flag_bits;
  logic [7:0]  reserved_byte;
  logic [31:0] sequence_res;
  logic [31:0] timestamp;
  logic [15:0] payload_length;
  logic [15:0] frame_checksum;

  modport source(output valid, status, magic, version, message_type, flag_bits,
                 reserved_byte, sequence_res, timestamp, payload_length,
                 frame_checksum, input ready);
  modport sink(input valid, status, magic, version, message_type, flag_bits,
               reserved_byte, sequence_res, timestamp, payload_length,
               frame_checksum, output ready);
endinterface

// ===== design/dfc_crc8.sv =====
// One-byte CRC-16/CCITT step, MSB first, eight shifts unrolled
module dfc_crc8 import dfc_pkg::*; (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ===== design/datagram_frame_checker.sv =====
// Datagram frame checker: takes one byte per beat and reports one verdict per
// datagram on its last byte. A new byte is accepted every cycle while the input
// is not stalled; the last byte of a datagram is held in the input register and
// its result is then written to the result register. The per-cycle limit is
// the unrolled eight-bit CRC-16/CCITT step followed by the checksum compare. The
// input stalls only when a last byte waits for a result register still full.
// Configuration (magic, version, max payload) is written through cfg_* while the
// block is idle, a user rule the block does not enforce; index 3 is ignored.
`include "datagram_frame_checker_macros.svh"

module datagram_frame_checker import dfc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dfc_in_if.sink                in_ch,
  dfc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic [15:0] magic_word_r;
  logic [7:0]  version_code_r;
  logic [15:0] max_payload_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_word_r   <= MAGIC_RST;
      version_code_r <= VERSION_RST;
      max_payload_r  <= MAX_PAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAGIC:   magic_word_r   <= cfg_wdata[15:0];
        CFG_VERSION: version_code_r <= cfg_wdata[7:0];
        CFG_MAX_PAY: max_payload_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_valid_r;
  result_t    res_r;
  logic       proc_fire;
  logic       out_free;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign proc_fire    = in_v_r && (!in_last_r || out_free);
  assign in_ch.ready  = !in_v_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.data_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

  // frame state
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] pay_idx;
  logic [15:0]        crc_r;
  logic [15:0]        crc_step;
  logic [15:0]        crc_nxt;
  logic [7:0]         hdr_r   [HEADER_BYTES];
  logic [7:0]         hdr_nxt [HEADER_BYTES];
  logic [15:0]        plen_cur;
  logic               crc_take;

  dfc_crc8 u_crc (
    .crc_in  (crc_r),
    .data    (in_byte_r),
    .crc_out (crc_step)
  );

  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
  assign plen_cur  = {hdr_r[14], hdr_r[15]};
  assign pay_idx   = count_r - COUNT_W'(HEADER_BYTES);
  assign crc_take  = (count_r < COUNT_W'(CRC_SPAN)) ||
                     ((count_r >= COUNT_W'(HEADER_BYTES)) && (pay_idx < {1'b0, plen_cur}));
  assign crc_nxt   = crc_take ? crc_step : crc_r;

  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      hdr_nxt[i] = (count_r == COUNT_W'(i)) ? in_byte_r : hdr_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= CRC_INIT;
    end else if (proc_fire) begin
      // start over after the last byte
      count_r <= in_last_r ? '0 : count_inc;
      crc_r   <= in_last_r ? CRC_INIT : crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      for (int i = 0; i < HEADER_BYTES; i++) begin
        hdr_r[i] <= hdr_nxt[i];
      end
    end
  end

  // verdict on the updated state
  logic [15:0] plen_n;
  logic [15:0] magic_n;
  logic [15:0] csum_n;
  logic        is_short;
  status_t     status_n;
  result_t     res_nxt;

  assign plen_n   = {hdr_nxt[14], hdr_nxt[15]};
  assign magic_n  = {hdr_nxt[0], hdr_nxt[1]};
  assign csum_n   = {hdr_nxt[16], hdr_nxt[17]};
  assign is_short = count_inc < COUNT_W'(HEADER_BYTES);

  always_comb begin
    if (is_short) begin
      status_n = ST_SHORT;
    end else if (magic_n != magic_word_r) begin
      status_n = ST_MAGIC;
    end else if (hdr_nxt[2] != version_code_r) begin
      status_n = ST_VERSION;
    end else if (hdr_nxt[5] != 8'h00) begin
      status_n = ST_FIELD;
    end else if (plen_n > max_payload_r) begin
      status_n = ST_FIELD;
    end else if ({1'b0, plen_n} > count_inc - COUNT_W'(HEADER_BYTES)) begin
      status_n = ST_FIELD;
    end else if (crc_nxt != csum_n) begin
      status_n = ST_CRC;
    end else begin
      status_n = ST_OK;
    end
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.status = status_n;
    // short frames report zero header fields
    if (!is_short) begin
      res_nxt.magic          = magic_n;
      res_nxt.version        = hdr_nxt[2];
      res_nxt.message_type   = hdr_nxt[3];
      res_nxt.flag_bits      = hdr_nxt[4];
      res_nxt.reserved_byte  = hdr_nxt[5];
      res_nxt.sequence_res   = {hdr_nxt[6], hdr_nxt[7], hdr_nxt[8], hdr_nxt[9]};
      res_nxt.timestamp      = {hdr_nxt[10], hdr_nxt[11], hdr_nxt[12], hdr_nxt[13]};
      res_nxt.payload_length = plen_n;
      res_nxt.frame_checksum = csum_n;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && in_last_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = res_r.status;
  assign out_ch.magic          = res_r.magic;
  assign out_ch.version        = res_r.version;
  assign out_ch.message_type   = res_r.message_type;
  assign out_ch.flag_bits      = res_r.flag_bits;
  assign out_ch.reserved_byte  = res_r.reserved_byte;
  assign out_ch.sequence_res   = res_r.sequence_res;
  assign out_ch.timestamp      = res_r.timestamp;
  assign out_ch.payload_length = res_r.payload_length;
  assign out_ch.frame_checksum = res_r.frame_checksum;

  `DFC_ASSERT_NEXT(a_clear_after_last, proc_fire && in_last_r,
                   count_r == '0 && crc_r == CRC_INIT,
                   "frame state not cleared after last byte")
  `DFC_ASSERT_NOW(a_rise_from_last, $rose(out_valid_r),
                  $past(proc_fire && in_last_r),
                  "result without a last byte")
  `DFC_ASSERT_NOW(a_short_zero, out_valid_r && res_r.status == ST_SHORT,
                  res_r.magic == '0 && res_r.payload_length == '0,
                  "short frame reports header fields")
  `DFC_ASSERT_NEXT(a_count_sat, proc_fire && !in_last_r && count_r == COUNT_MAX,
                   count_r == COUNT_MAX,
                   "byte count wrapped")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the datagram frame checker: random and directed datagrams
module tb_top;
  import dfc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int LONG_HOLD       = 400;
  localparam int MAX_REPORTS     = 100;

  typedef enum int {
    FK_GOOD, FK_SHORT, FK_MAGIC, FK_VERSION, FK_RESERVED,
    FK_TOOLONG, FK_TRUNC, FK_CRC, FK_NOISE
  } frame_kind_e;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dfc_in_if  in_ch();
  dfc_out_if out_ch();

  datagram_frame_checker uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // register copies, written together with the block's registers
  logic [15:0] magic_cfg   = MAGIC_RST;
  logic [7:0]  version_cfg = VERSION_RST;
  logic [15:0] max_pay_cfg = MAX_PAY_RST;

  // running view of the datagram in progress
  logic [COUNT_W-1:0] frame_cnt = '0;
  logic [15:0]        frame_crc = CRC_INIT;
  logic [7:0]         frame_hdr [HEADER_BYTES];

  beat_t      byte_q [$];
  result_t    verdict_q [$];
  logic [7:0] frame_buf [$];

  fill_e fill_mode = FILL_RANDOM;
  int gap_pct = 25;
  int stall_pct = 25;
  int gap_left = 0;
  int stall_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int errors = 0;
  int beats_sent = 0;
  int quiet_cycles = 0;

  initial foreach (frame_hdr[i]) frame_hdr[i] = '0;

  task automatic flag_error(input string msg);
    if (errors < MAX_REPORTS) $display("%s", msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("tb_top: %s got %0h want %0h", name, got, want));
  endtask

  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    int k;
    x = c ^ {b, 8'h00};
    for (k = 0; k < 8; k++) x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    return x;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] fill_byte();
    case (fill_mode)
      FILL_ONES:  return 8'hFF;
      FILL_ZEROS: return 8'h00;
      default:    return 8'($urandom);
    endcase
  endfunction

  // Advance the datagram view by one byte; on the last byte queue its verdict.
  task automatic track_byte(input logic [7:0] d, input logic lst);
    int idx;
    int plen;
    int n;
    result_t r;
    idx = int'(frame_cnt);
    if (idx < HEADER_BYTES) frame_hdr[idx] = d;
    if (idx < CRC_SPAN) begin
      frame_crc = crc16_next(frame_crc, d);
    end else if (idx >= HEADER_BYTES) begin
      plen = int'({frame_hdr[14], frame_hdr[15]});
      if (idx - HEADER_BYTES < plen) frame_crc = crc16_next(frame_crc, d);
    end
    if (frame_cnt != COUNT_MAX) frame_cnt = frame_cnt + 1'b1;
    if (lst) begin
      r = '0;
      n = int'(frame_cnt);
      if (n < HEADER_BYTES) begin
        r.status = ST_SHORT;
      end else begin
        r.magic          = {frame_hdr[0], frame_hdr[1]};
        r.version        = frame_hdr[2];
        r.message_type   = frame_hdr[3];
        r.flag_bits      = frame_hdr[4];
        r.reserved_byte  = frame_hdr[5];
        r.sequence_res   = {frame_hdr[6], frame_hdr[7], frame_hdr[8], frame_hdr[9]};
        r.timestamp      = {frame_hdr[10], frame_hdr[11], frame_hdr[12], frame_hdr[13]};
        r.payload_length = {frame_hdr[14], frame_hdr[15]};
        r.frame_checksum = {frame_hdr[16], frame_hdr[17]};
        plen = int'(r.payload_length);
        if (r.magic != magic_cfg) r.status = ST_MAGIC;
        else if (r.version != version_cfg) r.status = ST_VERSION;
        else if (r.reserved_byte != 8'h00) r.status = ST_FIELD;
        else if (r.payload_length > max_pay_cfg) r.status = ST_FIELD;
        else if (plen > n - HEADER_BYTES) r.status = ST_FIELD;
        else if (frame_crc != r.frame_checksum) r.status = ST_CRC;
        else r.status = ST_OK;
      end
      verdict_q.push_back(r);
      frame_cnt = '0;
      frame_crc = CRC_INIT;
      foreach (frame_hdr[i]) frame_hdr[i] = '0;
    end
  endtask

  task automatic trim_frame(input int keep);
    while (frame_buf.size() > keep) void'(frame_buf.pop_back());
  endtask

  // Build one datagram in frame_buf: header, payload, trailing bytes, then the fault.
  task automatic build_frame(input frame_kind_e kind, input int plen_in, input int trail);
    int plen;
    int sent;
    int i;
    int j;
    logic [15:0] plen16;
    logic [15:0] c;
    frame_buf.delete();
    if (kind == FK_NOISE) begin
      sent = $urandom_range(1, 40);
      for (i = 0; i < sent; i++) frame_buf.push_back(8'($urandom));
      return;
    end
    plen = plen_in;
    sent = plen_in;
    if (kind == FK_TOOLONG) begin
      plen = int'(max_pay_cfg) + 1 + $urandom_range(0, 3);
      if (plen > 65535) plen = 65535;
      sent = $urandom_range(0, 3);
    end
    if (kind == FK_TRUNC) sent = $urandom_range(0, plen - 1);
    plen16 = 16'(plen);
    frame_buf.push_back(magic_cfg[15:8]);
    frame_buf.push_back(magic_cfg[7:0]);
    frame_buf.push_back(version_cfg);
    frame_buf.push_back(fill_byte());
    frame_buf.push_back(fill_byte());
    frame_buf.push_back(8'h00);
    for (i = 6; i < 14; i++) frame_buf.push_back(fill_byte());
    frame_buf.push_back(plen16[15:8]);
    frame_buf.push_back(plen16[7:0]);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    for (i = 0; i < sent; i++) frame_buf.push_back(fill_byte());
    case (kind)
      FK_MAGIC: begin
        j = $urandom_range(0, 1);
        frame_buf[j] = frame_buf[j] ^ 8'(1 << $urandom_range(0, 7));
      end
      FK_VERSION:  frame_buf[2] = frame_buf[2] ^ 8'($urandom_range(1, 255));
      FK_RESERVED: frame_buf[5] = 8'($urandom_range(1, 255));
      default: ;
    endcase
    c = CRC_INIT;
    for (i = 0; i < CRC_SPAN; i++) c = crc16_next(c, frame_buf[i]);
    for (i = HEADER_BYTES; i < frame_buf.size(); i++) c = crc16_next(c, frame_buf[i]);
    frame_buf[16] = c[15:8];
    frame_buf[17] = c[7:0];
    if (kind != FK_TRUNC)
      for (i = 0; i < trail; i++) frame_buf.push_back(fill_byte());
    if (kind == FK_CRC) begin
      // corrupt the checksum, a payload byte or a covered header byte
      case ($urandom_range(0, 2))
        0: j = $urandom_range(16, 17);
        1: j = (plen > 0) ? HEADER_BYTES + $urandom_range(0, plen - 1) : 3;
        default: begin
          j = $urandom_range(3, 13);
          if (j == 5) j = 4;
        end
      endcase
      frame_buf[j] = frame_buf[j] ^ 8'($urandom_range(1, 255));
    end
    if (kind == FK_SHORT) trim_frame($urandom_range(1, HEADER_BYTES - 1));
  endtask

  task automatic send_frame();
    beat_t b;
    int i;
    for (i = 0; i < frame_buf.size(); i++) begin
      b.data = frame_buf[i];
      b.last = (i == frame_buf.size() - 1);
      byte_q.push_back(b);
    end
    beats_sent += frame_buf.size();
  endtask

  task automatic build_send(input frame_kind_e kind, input int plen, input int trail);
    build_frame(kind, plen, trail);
    send_frame();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MAGIC:   magic_cfg = val;
      CFG_VERSION: version_cfg = val[7:0];
      CFG_MAX_PAY: max_pay_cfg = val;
      default: ;
    endcase
  endtask

  // Hold until every beat is out and every verdict is back, then let the pipe settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (byte_q.size() != 0 || in_ch.valid || verdict_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int beats);
    int start_cnt;
    int r;
    int plen;
    int trail;
    frame_kind_e kind;
    start_cnt = beats_sent;
    while (beats_sent - start_cnt < beats) begin
      r = $urandom_range(0, 99);
      if (r < 55) kind = FK_GOOD;
      else if (r < 61) kind = FK_SHORT;
      else if (r < 66) kind = FK_MAGIC;
      else if (r < 71) kind = FK_VERSION;
      else if (r < 76) kind = FK_RESERVED;
      else if (r < 81) kind = FK_TOOLONG;
      else if (r < 87) kind = FK_TRUNC;
      else if (r < 94) kind = FK_CRC;
      else kind = FK_NOISE;
      if (kind == FK_TOOLONG && max_pay_cfg == 16'hFFFF) kind = FK_GOOD;
      r = $urandom_range(0, 9);
      if (r < 7) plen = $urandom_range(0, 8);
      else if (r < 9) plen = $urandom_range(0, 40);
      else plen = $urandom_range(0, 120);
      if (plen > max_pay_cfg) plen = int'(max_pay_cfg);
      if (kind == FK_TRUNC && plen == 0) plen = 1;
      trail = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 6);
      build_send(kind, plen, trail);
    end
  endtask

  // input driver: one beat per handshake, random gaps between beats
  always @(posedge clk) begin : drv
    logic fire;
    logic nv;
    beat_t b;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.last_byte <= 1'b0;
      gap_left = 0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) track_byte(in_ch.data_byte, in_ch.last_byte);
      nv = in_ch.valid && !fire;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_q.size() > 0) begin
          if ($urandom_range(0, 99) < gap_pct) begin
            gap_left = pick_gap() - 1;
          end else begin
            b = byte_q.pop_front();
            in_ch.data_byte <= b.data;
            in_ch.last_byte <= b.last;
            nv = 1'b1;
          end
        end
      end
      in_ch.valid <= nv;
    end
  end

  // verdict monitor: compare each beat with the oldest pending verdict
  always @(posedge clk) begin : mon
    logic rdy;
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          flag_error("tb_top: verdict with none pending");
        end else begin
          want = verdict_q.pop_front();
          check_field("status", 32'(out_ch.status), 32'(want.status));
          check_field("magic", 32'(out_ch.magic), 32'(want.magic));
          check_field("version", 32'(out_ch.version), 32'(want.version));
          check_field("message_type", 32'(out_ch.message_type), 32'(want.message_type));
          check_field("flag_bits", 32'(out_ch.flag_bits), 32'(want.flag_bits));
          check_field("reserved_byte", 32'(out_ch.reserved_byte), 32'(want.reserved_byte));
          check_field("sequence_res", out_ch.sequence_res, want.sequence_res);
          check_field("timestamp", out_ch.timestamp, want.timestamp);
          check_field("payload_length", 32'(out_ch.payload_length),
                      32'(want.payload_length));
          check_field("frame_checksum", 32'(out_ch.frame_checksum),
                      32'(want.frame_checksum));
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = pick_gap() - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ch.ready <= rdy;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tb_top: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin : stim
    int p;
    logic [15:0] mp;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values: field extremes, every verdict, short and long edges
    fill_mode = FILL_ZEROS;
    build_send(FK_GOOD, 0, 0);
    fill_mode = FILL_ONES;
    build_send(FK_GOOD, 3, 2);
    fill_mode = FILL_RANDOM;
    build_frame(FK_GOOD, 0, 0);
    trim_frame(1);
    send_frame();
    build_frame(FK_GOOD, 2, 0);
    trim_frame(HEADER_BYTES - 1);
    send_frame();
    build_send(FK_GOOD, 5, 3);
    build_send(FK_GOOD, 0, 4);
    build_send(FK_SHORT, 0, 0);
    build_send(FK_MAGIC, 2, 0);
    build_send(FK_VERSION, 2, 0);
    build_send(FK_RESERVED, 2, 0);
    build_send(FK_TOOLONG, 0, 0);
    build_send(FK_TRUNC, 6, 0);
    build_send(FK_CRC, 4, 0);
    build_send(FK_CRC, 4, 1);
    build_send(FK_CRC, 4, 0);
    build_send(FK_NOISE, 0, 0);
    wait_idle();

    // all-ones magic and version, no payload allowed
    write_reg(CFG_MAGIC, 16'hFFFF);
    write_reg(CFG_VERSION, 16'h00FF);
    write_reg(CFG_MAX_PAY, 16'h0000);
    fill_mode = FILL_ONES;
    build_send(FK_GOOD, 0, 0);
    fill_mode = FILL_RANDOM;
    build_send(FK_TOOLONG, 0, 0);
    build_send(FK_GOOD, 0, 5);
    run_random(100);
    wait_idle();

    // zero magic and version, largest payload limit, beats back to back
    write_reg(CFG_MAGIC, 16'h0000);
    write_reg(CFG_VERSION, 16'h0000);
    write_reg(CFG_MAX_PAY, 16'hFFFF);
    gap_pct = 0;
    stall_pct = 0;
    build_send(FK_GOOD, 100, 0);
    build_send(FK_GOOD, 30, 6);
    wait_idle();
    write_reg(CFG_UNUSED, 16'($urandom));
    gap_pct = 25;
    stall_pct = 25;
    build_send(FK_GOOD, 3, 0);
    build_send(FK_VERSION, 1, 0);
    wait_idle();

    for (p = 0; p < 6; p++) begin
      write_reg(CFG_MAGIC, 16'($urandom));
      write_reg(CFG_VERSION, 16'($urandom));
      case ($urandom_range(0, 2))
        0: mp = 16'($urandom_range(0, 40));
        1: mp = 16'($urandom);
        default: mp = MAX_PAY_RST;
      endcase
      write_reg(CFG_MAX_PAY, mp);
      case (p % 3)
        0: begin gap_pct = 25; stall_pct = 25; end
        1: begin gap_pct = 0; stall_pct = 50; end
        default: begin gap_pct = 50; stall_pct = 0; end
      endcase
      // hold the receiver off while a full queue of beats is offered
      if (p == 0) hold_req = 1'b1;
      run_random(210);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0)
      flag_error($sformatf("tb_top: %0d verdicts never arrived", verdict_q.size()));
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
